// ===== hdl/msbp_pkg.sv =====
// ----------------------------------------------------------------------------
// msbp_pkg: shared types and constants of the Morse symbol bit packer
// Character codes, the symbol-to-timing-pattern lookup, and the words
// that pass between the step logic, the result queue and the top level.
// ----------------------------------------------------------------------------
package msbp_pkg;

    // Default width of the saturating message bit counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Field widths
    localparam int CharW      = 8;
    localparam int ByteW      = 8;
    localparam int NbitsW     = 4;
    localparam int TotalBitsW = 16;
    localparam int PendW      = 7;
    localparam int PendCntW   = 3;

    // Coded characters
    localparam logic [CharW-1:0] ChDot   = 8'd46;
    localparam logic [CharW-1:0] ChDash  = 8'd45;
    localparam logic [CharW-1:0] ChSpace = 8'd32;
    localparam logic [CharW-1:0] ChSlash = 8'd47;
    localparam logic [CharW-1:0] ChTab   = 8'd9;

    // Bits in a full byte
    localparam logic [NbitsW-1:0] FullByteBits = 4'd8;

    // Timing pattern of one character, right aligned
    typedef struct packed {
        logic [PendW-1:0]    bits;
        logic [PendCntW-1:0] len;
    } t_pattern;

    // Input word
    typedef struct packed {
        logic [CharW-1:0] symbol_char;
        logic             message_end;
    } t_symbol;

    // Result word
    typedef struct packed {
        logic [ByteW-1:0]      packed_byte;
        logic [NbitsW-1:0]     bits_in_byte;
        logic [TotalBitsW-1:0] total_bits;
        logic                  last_of_message;
    } t_result;

    // Results and pending state produced by one symbol
    typedef struct packed {
        t_result             first;
        t_result             second;
        logic [1:0]          push_n;
        logic [PendW-1:0]    pend_bits;
        logic [PendCntW-1:0] pend_cnt;
    } t_step;

    // Map a character to its on/off timing pattern
    function automatic t_pattern expand_char(input logic [CharW-1:0] c);
        t_pattern p;
        p.bits = '0;
        p.len  = '0;
        if (c == ChDot) begin
            p.bits = 7'h01;
            p.len  = 3'd1;
        end else if (c == ChDash) begin
            p.bits = 7'h07;
            p.len  = 3'd3;
        end else if (c == ChSpace) begin
            p.len  = 3'd1;
        end else if (c == ChSlash) begin
            p.len  = 3'd3;
        end else if (c == ChTab) begin
            p.len  = 3'd7;
        end
        return p;
    endfunction

endpackage

// ===== hdl/msbp_sym_if.sv =====
// ----------------------------------------------------------------------------
// msbp_sym_if: symbol input channel
// Valid/ready channel carrying one Morse text character per word.
// ----------------------------------------------------------------------------
interface msbp_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_char;
    logic       message_end;

    modport source (output valid, output symbol_char, output message_end, input ready);
    modport sink   (input valid, input symbol_char, input message_end, output ready);
endinterface

// ===== hdl/msbp_res_if.sv =====
// ----------------------------------------------------------------------------
// msbp_res_if: packed result channel
// Valid/ready channel carrying one packed byte and its counts per word.
// ----------------------------------------------------------------------------
interface msbp_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packed_byte;
    logic [3:0]  bits_in_byte;
    logic [15:0] total_bits;
    logic        last_of_message;

    modport source (
        output valid, output packed_byte, output bits_in_byte,
        output total_bits, output last_of_message, input ready
    );
    modport sink (
        input valid, input packed_byte, input bits_in_byte,
        input total_bits, input last_of_message, output ready
    );
endinterface

// ===== hdl/morse_symbol_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// morse_symbol_bit_packer_core: Morse symbol bit packer
// Expands Morse text into timing bits and packs them into bytes.
// ----------------------------------------------------------------------------
// Takes one character word per cycle while the result queue has room:
// '.' -> 1, '-' -> 111, space -> 0, '/' -> 000, tab -> 0000000, anything
// else adds nothing. Bits are packed first-bit-in-bit-7; each full byte
// leaves as a result word, and the word flagged as message end flushes a
// zero-padded tail with last_of_message set; if no bits remain, the full
// byte carries the flag, or an empty marker does if there is none. The
// bit count saturates at 2^COUNT_WIDTH - 1; total_bits is its low 16 bits.
// A symbol is held in the input register, and its results enter a
// four-word queue once the queue has room. One symbol per cycle is
// sustained while the queue has room; a symbol waits in the input register
// only while the queue holds more than two words, which happens when message
// ends that yield two results come close together or the sink stalls.
module morse_symbol_bit_packer_core
    import msbp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msbp_sym_if.sink    i_sym,
    msbp_res_if.source  o_res
);

    logic                   r_in_valid;
    t_symbol                r_in;
    logic [PendW-1:0]       r_pend_bits;
    logic [PendCntW-1:0]    r_pend_cnt;
    logic [COUNT_WIDTH-1:0] r_total;

    t_step                  step;
    logic [COUNT_WIDTH-1:0] n_total;
    logic                   room;
    logic                   fire;
    logic [1:0]             push_n;
    t_result                res_data;

    assign fire        = r_in_valid && room;
    assign i_sym.ready = !r_in_valid || fire;
    assign push_n      = fire ? step.push_n : 2'd0;

    // Hold the accepted symbol word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sym.ready) begin
            r_in_valid <= i_sym.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sym.ready && i_sym.valid) begin
            r_in.symbol_char <= i_sym.symbol_char;
            r_in.message_end <= i_sym.message_end;
        end
    end

    // Advance packing state per processed symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_total     <= '0;
        end else if (fire) begin
            r_pend_bits <= step.pend_bits;
            r_pend_cnt  <= step.pend_cnt;
            r_total     <= n_total;
        end
    end

    msbp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_sym        (r_in),
        .i_pend_bits  (r_pend_bits),
        .i_pend_cnt   (r_pend_cnt),
        .i_total      (r_total),
        .o_step       (step),
        .o_total_next (n_total)
    );

    msbp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_first  (step.first),
        .i_second (step.second),
        .o_room   (room),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_data   (res_data)
    );

    // Drive the result channel
    assign o_res.packed_byte     = res_data.packed_byte;
    assign o_res.bits_in_byte    = res_data.bits_in_byte;
    assign o_res.total_bits      = res_data.total_bits;
    assign o_res.last_of_message = res_data.last_of_message;

endmodule

// ===== hdl/msbp_step.sv =====
// ----------------------------------------------------------------------------
// msbp_step: per-symbol packing logic
// Expands one character, merges it with the pending bits, splits off a full
// byte and, at a message end, the zero-padded tail or an empty marker.
// ----------------------------------------------------------------------------
module msbp_step
    import msbp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  t_symbol                i_sym,
    input  logic [PendW-1:0]       i_pend_bits,
    input  logic [PendCntW-1:0]    i_pend_cnt,
    input  logic [COUNT_WIDTH-1:0] i_total,
    output t_step                  o_step,
    output logic [COUNT_WIDTH-1:0] o_total_next
);

    localparam int ExtW = (COUNT_WIDTH > TotalBitsW) ? COUNT_WIDTH : TotalBitsW;

    t_pattern               pat;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] total_sat;
    logic [ExtW-1:0]        total_ext;
    logic [13:0]            acc;
    logic [NbitsW-1:0]      cnt;
    logic                   full;
    logic [PendCntW-1:0]    rest;
    logic [PendW-1:0]       rem;
    t_result                full_res;
    t_result                tail_res;
    logic                   tail_valid;

    assign pat = expand_char(i_sym.symbol_char);

    // Saturating bit count
    assign sum       = {1'b0, i_total} + (COUNT_WIDTH + 1)'(pat.len);
    assign total_sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    assign total_ext = ExtW'(total_sat);

    // Merge new bits below the pending ones
    assign acc  = ({7'b0, i_pend_bits} << pat.len) | 14'(pat.bits);
    assign cnt  = {1'b0, i_pend_cnt} + {1'b0, pat.len};
    assign full = cnt[3];
    assign rest = cnt[2:0];
    assign rem  = acc[PendW-1:0] & ~(7'h7F << rest);

    always_comb begin
        // Full byte, oldest bit in bit 7
        full_res.packed_byte     = 8'(acc >> rest);
        full_res.bits_in_byte    = FullByteBits;
        full_res.total_bits      = total_ext[TotalBitsW-1:0];
        full_res.last_of_message = i_sym.message_end && (rest == '0);

        // Tail byte, or empty end marker when nothing is left
        tail_res.packed_byte     = 8'({1'b0, rem} << (4'd8 - {1'b0, rest}));
        tail_res.bits_in_byte    = {1'b0, rest};
        tail_res.total_bits      = total_ext[TotalBitsW-1:0];
        tail_res.last_of_message = 1'b1;
        tail_valid = i_sym.message_end && ((rest != '0) || !full);

        // Order: full byte first, tail second
        o_step.first  = full ? full_res : tail_res;
        o_step.second = tail_res;
        o_step.push_n = {1'b0, full} + {1'b0, tail_valid};

        // Clear state at a message end
        if (i_sym.message_end) begin
            o_step.pend_bits = '0;
            o_step.pend_cnt  = '0;
            o_total_next     = '0;
        end else begin
            o_step.pend_bits = rem;
            o_step.pend_cnt  = rest;
            o_total_next     = total_sat;
        end
    end

endmodule

// ===== hdl/msbp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// msbp_result_fifo: result queue
// Four-word queue that takes up to two result words per cycle and hands
// out one per cycle while i_ready is high; reports room for one symbol's results.
// ----------------------------------------------------------------------------
module msbp_result_fifo
    import msbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_first,
    input  t_result    i_second,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_data
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    t_result         r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;
    logic [PtrW-1:0] wr_ptr_1;
    logic            pop;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= (PtrW + 1)'(Depth - 2));
    assign wr_ptr_1 = r_wr_ptr + PtrW'(1);

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(i_push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            r_count <= r_count + (PtrW + 1)'(i_push_n) - (PtrW + 1)'(pop);
        end
    end

    // Store incoming words
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_first;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr_1] <= i_second;
        end
    end

endmodule

// ===== hdl/msbp_checker.sv =====
// ----------------------------------------------------------------------------
// msbp_checker: port-level checks of the Morse symbol bit packer
// Watches the result channel for stable stalls and consistent byte words.
// ----------------------------------------------------------------------------
module msbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [7:0]  i_packed_byte,
    input logic [3:0]  i_bits_in_byte,
    input logic [15:0] i_total_bits,
    input logic        i_last
);

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_packed_byte)
            && $stable(i_bits_in_byte) && $stable(i_total_bits) && $stable(i_last))
        else $error("result word changed while stalled");

    // Drop nothing out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // A word that does not end the message carries a full byte
    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_last |-> i_bits_in_byte == 4'd8)
        else $error("partial byte before message end");

    // The empty end marker has no bits and the count never exceeds a byte
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_bits_in_byte <= 4'd8)
            && ((i_bits_in_byte != 4'd0) || (i_last && i_packed_byte == 8'd0)))
        else $error("malformed empty end marker");

endmodule

bind morse_symbol_bit_packer_core msbp_checker u_msbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_packed_byte  (o_res.packed_byte),
    .i_bits_in_byte (o_res.bits_in_byte),
    .i_total_bits   (o_res.total_bits),
    .i_last         (o_res.last_of_message)
);
